>>> rtl/pr2d_pkg.sv
// Shared types and constants of the 2D point rotator.
package pr2d_pkg;

  localparam int ANGLE_W    = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ANGLE = 2'd2;

  localparam int TURN_W     = 15;
  localparam int REM_W      = 13;
  localparam logic signed [ANGLE_W+1:0] FULL_TURN   = 18'sd23040;
  localparam logic signed [ANGLE_W+1:0] DOUBLE_TURN = 18'sd46080;
  localparam logic [TURN_W-1:0] QUARTER_1 = 15'd5760;
  localparam logic [TURN_W-1:0] QUARTER_2 = 15'd11520;
  localparam logic [TURN_W-1:0] QUARTER_3 = 15'd17280;

  // A quarter-turn remainder times RECIP_TURN, shifted down by RECIP_SHIFT, is the
  // angle in units of 2^32 per turn, exact over the whole remainder range.
  localparam int RECIP_W     = 36;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W      = REM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_TURN = 36'd48867183457;

  localparam int CNT_W         = 6;
  localparam int CORDIC_STEPS  = 30;
  localparam int STEP_W        = 5;
  localparam int CORDIC_W      = 36;
  localparam int CORDIC_FRAC   = 32;
  localparam int ZW            = 33;
  localparam logic [CNT_W-1:0] CORDIC_LAST = 6'd29;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 36'sd2608131496;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_REDUCE,
    TS_SPLIT,
    TS_DIVIDE,
    TS_ROTATE,
    TS_FINISH
  } trig_state_e;

endpackage

>>> rtl/pr2d_trig.sv
// Sequential cosine and sine generator: angle reduction, reciprocal divide and CORDIC.
module pr2d_trig #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [pr2d_pkg::ANGLE_W-1:0]       angle_i,
  output logic                               busy_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   cos_o,
  output logic signed [TRIG_FRAC_BITS+1:0]   sin_o
);
  import pr2d_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int SH = CORDIC_FRAC - TRIG_FRAC_BITS;
  localparam int RW = CORDIC_W - SH;
  localparam logic signed [TW-1:0] ONE_T = {2'b01, {TRIG_FRAC_BITS{1'b0}}};
  localparam logic signed [RW-1:0] ONE_R =
    {{(RW-TRIG_FRAC_BITS-1){1'b0}}, 1'b1, {TRIG_FRAC_BITS{1'b0}}};
  localparam logic signed [CORDIC_W-1:0] HALF_R =
    {{(CORDIC_W-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};

  trig_state_e state_q, state_d;

  logic signed [ANGLE_W-1:0]   ang_q;
  logic [TURN_W-1:0]           turn_q;
  logic [1:0]                  quad_q;
  logic                        zero_q;
  logic [REM_W-1:0]            rem_q;
  logic [CNT_W-1:0]            cnt_q;
  logic signed [ZW-1:0]        z_q;
  logic signed [CORDIC_W-1:0]  x_q, y_q;
  logic signed [TW-1:0]        cos_q, sin_q;

  logic signed [ANGLE_W+1:0]   ang_ext;
  logic signed [ANGLE_W+1:0]   red_full;
  logic [1:0]                  quad_d;
  logic [TURN_W-1:0]           rem_full;
  logic [PROD_W-1:0]           z_prod;
  logic signed [CORDIC_W-1:0]  x_sh, y_sh;
  logic signed [ZW-1:0]        atan_z;
  logic signed [TW-1:0]        c_r, s_r, c_f, s_f;

  function automatic logic signed [TW-1:0] round_clamp(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] b;
    logic signed [RW-1:0]       r;
    b = v + HALF_R;
    r = b[CORDIC_W-1:SH];
    if (r < 0) begin
      round_clamp = '0;
    end else if (r > ONE_R) begin
      round_clamp = ONE_T;
    end else begin
      round_clamp = r[TW-1:0];
    end
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      TS_IDLE:   if (start_i) state_d = TS_REDUCE;
      TS_REDUCE: state_d = TS_SPLIT;
      TS_SPLIT:  state_d = (rem_full[REM_W-1:0] == '0) ? TS_FINISH : TS_DIVIDE;
      TS_DIVIDE: state_d = TS_ROTATE;
      TS_ROTATE: if (cnt_q == CORDIC_LAST) state_d = TS_FINISH;
      TS_FINISH: state_d = TS_IDLE;
      default:   state_d = TS_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != TS_IDLE);
  end

  always_comb begin
    ang_ext = {{2{ang_q[ANGLE_W-1]}}, ang_q};
    if (ang_ext < -FULL_TURN) begin
      red_full = ang_ext + DOUBLE_TURN;
    end else if (ang_ext < 0) begin
      red_full = ang_ext + FULL_TURN;
    end else if (ang_ext >= FULL_TURN) begin
      red_full = ang_ext - FULL_TURN;
    end else begin
      red_full = ang_ext;
    end
  end

  always_comb begin
    if (turn_q >= QUARTER_3) begin
      quad_d   = 2'd3;
      rem_full = turn_q - QUARTER_3;
    end else if (turn_q >= QUARTER_2) begin
      quad_d   = 2'd2;
      rem_full = turn_q - QUARTER_2;
    end else if (turn_q >= QUARTER_1) begin
      quad_d   = 2'd1;
      rem_full = turn_q - QUARTER_1;
    end else begin
      quad_d   = 2'd0;
      rem_full = turn_q;
    end
  end

  always_comb begin
    z_prod = rem_q * RECIP_TURN;
    x_sh   = x_q >>> cnt_q[STEP_W-1:0];
    y_sh   = y_q >>> cnt_q[STEP_W-1:0];
    atan_z = $signed({1'b0, ATAN_TAB[cnt_q[STEP_W-1:0]]});
  end

  always_comb begin
    if (zero_q) begin
      c_r = ONE_T;
      s_r = '0;
    end else begin
      c_r = round_clamp(x_q);
      s_r = round_clamp(y_q);
    end
    case (quad_q)
      2'd1:    begin c_f = -s_r; s_f = c_r;  end
      2'd2:    begin c_f = -c_r; s_f = -s_r; end
      2'd3:    begin c_f = s_r;  s_f = -c_r; end
      default: begin c_f = c_r;  s_f = s_r;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TS_IDLE;
      cnt_q   <= '0;
      cos_q   <= ONE_T;
      sin_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        TS_SPLIT:  cnt_q <= '0;
        TS_ROTATE: cnt_q <= cnt_q + 1'b1;
        TS_FINISH: begin
          cos_q <= c_f;
          sin_q <= s_f;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      TS_IDLE: if (start_i) ang_q <= angle_i;
      TS_REDUCE: turn_q <= red_full[TURN_W-1:0];
      TS_SPLIT: begin
        quad_q <= quad_d;
        zero_q <= (rem_full[REM_W-1:0] == '0);
        rem_q  <= rem_full[REM_W-1:0];
        x_q    <= CORDIC_X0;
        y_q    <= '0;
      end
      TS_DIVIDE: begin
        z_q <= {{(ZW-PROD_W+RECIP_SHIFT){1'b0}}, z_prod[PROD_W-1:RECIP_SHIFT]};
      end
      TS_ROTATE: begin
        if (z_q >= 0) begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - atan_z;
        end else begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + atan_z;
        end
      end
      default: ;
    endcase
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

>>> rtl/pr2d_pipe.sv
// Four-stage point rotation pipeline: offset, multiply, sum and truncate, recenter and saturate.
module pr2d_pipe #(
  parameter int COORD_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [COORD_WIDTH-1:0]    point_x_i,
  input  logic signed [COORD_WIDTH-1:0]    point_y_i,
  input  logic signed [COORD_WIDTH-1:0]    center_x_i,
  input  logic signed [COORD_WIDTH-1:0]    center_y_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_i,
  output logic                             busy_o,
  output logic                             valid_o,
  output logic signed [COORD_WIDTH-1:0]    rotated_x_o,
  output logic signed [COORD_WIDTH-1:0]    rotated_y_o,
  output logic                             clipped_o
);
  localparam int CW = COORD_WIDTH;
  localparam int F  = TRIG_FRAC_BITS;
  localparam int DW = CW + 1;
  localparam int PW = DW + F + 2;
  localparam int SW = PW + 1;
  localparam int TW = SW - F;
  localparam int RW = TW + 1;
  localparam logic signed [RW-1:0] MAX_R = {{(RW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [RW-1:0] MIN_R = {{(RW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] TRUNC_BIAS = {{(SW-F){1'b0}}, {F{1'b1}}};

  logic [3:0]              vld_q;
  logic signed [DW-1:0]    dx_q, dy_q;
  logic signed [PW-1:0]    pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [TW-1:0]    tx_q, ty_q;
  logic signed [CW-1:0]    rx_q, ry_q;
  logic                    clip_q;

  logic signed [DW-1:0]    dx_d, dy_d;
  logic signed [SW-1:0]    sx, sy, sxb, syb;
  logic signed [RW-1:0]    rx_full, ry_full;
  logic                    hx, lx, hy, ly;

  always_comb begin
    dx_d = {point_x_i[CW-1], point_x_i} - {center_x_i[CW-1], center_x_i};
    dy_d = {point_y_i[CW-1], point_y_i} - {center_y_i[CW-1], center_y_i};
    sx   = {pxc_q[PW-1], pxc_q} - {pys_q[PW-1], pys_q};
    sy   = {pxs_q[PW-1], pxs_q} + {pyc_q[PW-1], pyc_q};
    sxb  = sx + (sx[SW-1] ? TRUNC_BIAS : '0);
    syb  = sy + (sy[SW-1] ? TRUNC_BIAS : '0);
    rx_full = {tx_q[TW-1], tx_q} + {{(RW-CW){center_x_i[CW-1]}}, center_x_i};
    ry_full = {ty_q[TW-1], ty_q} + {{(RW-CW){center_y_i[CW-1]}}, center_y_i};
    hx = (rx_full > MAX_R);
    lx = (rx_full < MIN_R);
    hy = (ry_full > MAX_R);
    ly = (ry_full < MIN_R);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    pxc_q  <= dx_q * cos_i;
    pys_q  <= dy_q * sin_i;
    pxs_q  <= dx_q * sin_i;
    pyc_q  <= dy_q * cos_i;
    tx_q   <= sxb[SW-1:F];
    ty_q   <= syb[SW-1:F];
    rx_q   <= hx ? MAX_C : (lx ? MIN_C : rx_full[CW-1:0]);
    ry_q   <= hy ? MAX_C : (ly ? MIN_C : ry_full[CW-1:0]);
    clip_q <= hx | lx | hy | ly;
  end

  assign busy_o      = |vld_q[2:0];
  assign valid_o     = vld_q[3];
  assign rotated_x_o = rx_q;
  assign rotated_y_o = ry_q;
  assign clipped_o   = clip_q;

endmodule

>>> rtl/point_rotator_2d.sv
// Top level of the 2D point rotator: configuration registers, trig generator and pipeline.
// The result of an accepted request passes the offset, multiply, sum and recenter registers.
// Throughput: one point per cycle while busy_o is low; configuration waits for an empty pipe.
// A rotation_angle write holds busy_o high through reduce, split, reciprocal divide,
// 30 CORDIC steps and finish, or through reduce, split and finish for a multiple of 90 degrees.
// Reset clears the centers, sets cosine to one and sine to zero.
module point_rotator_2d #(
  parameter int COORD_WIDTH    = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [COORD_WIDTH-1:0]         point_x_i,
  input  logic signed [COORD_WIDTH-1:0]         point_y_i,
  output logic                                  result_valid_o,
  output logic signed [COORD_WIDTH-1:0]         rotated_x_o,
  output logic signed [COORD_WIDTH-1:0]         rotated_y_o,
  output logic                                  clipped_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pr2d_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [((COORD_WIDTH > pr2d_pkg::ANGLE_W) ?
                 COORD_WIDTH : pr2d_pkg::ANGLE_W)-1:0] cfg_data_i
);
  import pr2d_pkg::*;

  logic signed [COORD_WIDTH-1:0]    center_x_q, center_y_q;
  logic signed [TRIG_FRAC_BITS+1:0] cos_w, sin_w;
  logic                             cfg_we;
  logic                             angle_we;
  logic                             trig_busy;
  logic                             pipe_busy;

  assign cfg_ready_o = !trig_busy && !pipe_busy && !start_i;
  assign busy_o      = trig_busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign angle_we    = cfg_we && (cfg_index_i == REG_ROTATION_ANGLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_CENTER_X: center_x_q <= cfg_data_i[COORD_WIDTH-1:0];
        REG_CENTER_Y: center_y_q <= cfg_data_i[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  pr2d_trig #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (angle_we),
    .angle_i (cfg_data_i[ANGLE_W-1:0]),
    .busy_o  (trig_busy),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  pr2d_pipe #(
    .COORD_WIDTH   (COORD_WIDTH),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start_i && !trig_busy),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .cos_i       (cos_w),
    .sin_i       (sin_w),
    .busy_o      (pipe_busy),
    .valid_o     (result_valid_o),
    .rotated_x_o (rotated_x_o),
    .rotated_y_o (rotated_y_o),
    .clipped_o   (clipped_o)
  );

endmodule

>>> rtl/pr2d_checker.sv
// Port-level assertions for the 2D point rotator and their binding to the top level.
module pr2d_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start_i,
  input logic                               busy_o,
  input logic                               result_valid_o,
  input logic signed [COORD_WIDTH-1:0]      rotated_x_o,
  input logic signed [COORD_WIDTH-1:0]      rotated_y_o,
  input logic                               clipped_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [pr2d_pkg::CFG_IDX_W-1:0]     cfg_index_i
);
  import pr2d_pkg::*;

  localparam logic signed [COORD_WIDTH-1:0] MAX_C = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] MIN_C = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Every accepted request produces its result after passing through the pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 result_valid_o)
    else $error("accepted request produced no result after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 4))
    else $error("result strobe without a matching request");

  // The trig unit only starts on an angle write.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_ROTATION_ANGLE)))
    else $error("busy raised without an angle write");

  a_angle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_ROTATION_ANGLE)) |=> busy_o)
    else $error("angle write did not start the trig unit");

  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && clipped_o) |->
      (rotated_x_o == MAX_C || rotated_x_o == MIN_C ||
       rotated_y_o == MAX_C || rotated_y_o == MIN_C))
    else $error("clipped result with no coordinate at a limit");

endmodule

bind point_rotator_2d pr2d_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_pr2d_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .rotated_x_o    (rotated_x_o),
  .rotated_y_o    (rotated_y_o),
  .clipped_o      (clipped_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o),
  .cfg_index_i    (cfg_index_i)
);

>>> dv/testbench.sv
// Self-checking testbench for point_rotator_2d: directed table, then randomized phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int AW = pr2d_pkg::ANGLE_W;
  localparam longint TRIG_ONE = 64'sd32768;
  localparam longint TURN = 64'sd23040;
  localparam longint QUARTER = 64'sd5760;
  localparam longint COORD_MAX = 64'sd32767;
  localparam longint COORD_MIN = -64'sd32768;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES = 8;
  localparam int PHASE_POINTS = 100;
  localparam logic [pr2d_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam longint ARCTAN [30] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
  };

  typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_e;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 clip;
  } rotation_t;

  typedef struct {
    row_kind_e                         kind;
    logic [pr2d_pkg::CFG_IDX_W-1:0]    idx;
    logic [AW-1:0]                     data;
    logic signed [CW-1:0]              px;
    logic signed [CW-1:0]              py;
    bit                                typed;
    rotation_t                         want;
  } plan_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start_i = 1'b0;
  logic                           busy_o;
  logic signed [CW-1:0]           point_x_i = '0;
  logic signed [CW-1:0]           point_y_i = '0;
  logic                           result_valid_o;
  logic signed [CW-1:0]           rotated_x_o;
  logic signed [CW-1:0]           rotated_y_o;
  logic                           clipped_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [pr2d_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [AW-1:0]                  cfg_data_i = '0;

  logic signed [CW-1:0] ctr_x;
  logic signed [CW-1:0] ctr_y;
  logic signed [16:0]   cos_q;
  logic signed [16:0]   sin_q;

  rotation_t rotated_points_due [$];
  plan_row_t plan [$];
  rotation_t due;
  int failures = 0;
  int n_points = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_clipped = 0;
  int quiet_cycles = 0;

  point_rotator_2d u_top (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 64'sd65536) >>> 17;
    if (r < 0) r = 0;
    if (r > TRIG_ONE) r = TRIG_ONE;
    return r;
  endfunction

  function automatic void load_trig(logic signed [AW-1:0] ang);
    longint a, q, r, c, s, x, y, z, nx;
    a = longint'(ang) % TURN;
    if (a < 0) a += TURN;
    q = a / QUARTER;
    r = a % QUARTER;
    if (r == 0) begin
      c = TRIG_ONE;
      s = 0;
    end else begin
      x = 64'sd2608131496;
      y = 0;
      z = (r <<< 32) / TURN;
      for (int i = 0; i < 30; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= ARCTAN[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += ARCTAN[i];
        end
        x = nx;
      end
      c = round_q15(x);
      s = round_q15(y);
    end
    case (q)
      1: begin
        cos_q = 17'(-s);
        sin_q = 17'(c);
      end
      2: begin
        cos_q = 17'(-c);
        sin_q = 17'(-s);
      end
      3: begin
        cos_q = 17'(s);
        sin_q = 17'(-c);
      end
      default: begin
        cos_q = 17'(c);
        sin_q = 17'(s);
      end
    endcase
  endfunction

  function automatic longint trunc_q15(longint v);
    if (v >= 0) return v >>> 15;
    return -((-v) >>> 15);
  endfunction

  function automatic rotation_t rotate_about_center(logic signed [CW-1:0] px,
                                                    logic signed [CW-1:0] py);
    longint dx, dy, rx, ry;
    rotation_t res;
    dx = longint'(px) - longint'(ctr_x);
    dy = longint'(py) - longint'(ctr_y);
    rx = trunc_q15(dx * longint'(cos_q) - dy * longint'(sin_q)) + longint'(ctr_x);
    ry = trunc_q15(dx * longint'(sin_q) + dy * longint'(cos_q)) + longint'(ctr_y);
    res.clip = 1'b0;
    if (rx > COORD_MAX) begin
      rx = COORD_MAX;
      res.clip = 1'b1;
    end else if (rx < COORD_MIN) begin
      rx = COORD_MIN;
      res.clip = 1'b1;
    end
    if (ry > COORD_MAX) begin
      ry = COORD_MAX;
      res.clip = 1'b1;
    end else if (ry < COORD_MIN) begin
      ry = COORD_MIN;
      res.clip = 1'b1;
    end
    res.x = rx[CW-1:0];
    res.y = ry[CW-1:0];
    return res;
  endfunction

  function automatic void add_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                    bit typed = 0, logic signed [CW-1:0] ex = 0,
                                    logic signed [CW-1:0] ey = 0, logic ec = 0);
    plan_row_t row;
    row.kind = ROW_POINT;
    row.idx = '0;
    row.data = '0;
    row.px = px;
    row.py = py;
    row.typed = typed;
    row.want = '{x: ex, y: ey, clip: ec};
    plan.push_back(row);
  endfunction

  function automatic void add_write(logic [pr2d_pkg::CFG_IDX_W-1:0] idx, logic [AW-1:0] data);
    plan_row_t row;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.data = data;
    row.px = '0;
    row.py = '0;
    row.typed = 0;
    row.want = '0;
    plan.push_back(row);
  endfunction

  function automatic logic [CW-1:0] pick_center();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return '0;
      3: return CW'($urandom_range(0, 400)) - CW'(200);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [AW-1:0] pick_angle(int ph);
    if (ph == 0) return 16'h8000;
    if (ph == 1) return 16'h7FFF;
    case ($urandom_range(0, 4))
      0: return AW'(QUARTER * $urandom_range(0, 5) * (($urandom_range(0, 1) != 0) ? 1 : -1));
      1: return AW'(QUARTER * $urandom_range(0, 5)) + AW'($urandom_range(0, 6)) - AW'(3);
      default: return AW'($urandom);
    endcase
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(logic signed [CW-1:0] ctr);
    case ($urandom_range(0, 9))
      6, 7: return ctr + CW'($urandom_range(0, 64)) - CW'(32);
      8: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic drain();
    start_i <= 1'b0;
    while (rotated_points_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [pr2d_pkg::CFG_IDX_W-1:0] idx, logic [AW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      pr2d_pkg::REG_CENTER_X: ctr_x = data[CW-1:0];
      pr2d_pkg::REG_CENTER_Y: ctr_y = data[CW-1:0];
      pr2d_pkg::REG_ROTATION_ANGLE: load_trig(data);
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            bit typed, rotation_t want);
    rotation_t predicted;
    predicted = typed ? want : rotate_about_center(px, py);
    start_i <= 1'b1;
    point_x_i <= px;
    point_y_i <= py;
    do @(posedge clk_i); while (busy_o);
    rotated_points_due.push_back(predicted);
    n_points++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (clipped_o) n_clipped++;
      if (rotated_points_due.size() == 0) begin
        $error("result with no request outstanding: x=%0d y=%0d clipped=%0d",
               rotated_x_o, rotated_y_o, clipped_o);
        failures++;
      end else begin
        due = rotated_points_due.pop_front();
        if (rotated_x_o !== due.x) begin
          $error("rotated_x: expected %0d, got %0d", due.x, rotated_x_o);
          failures++;
        end
        if (rotated_y_o !== due.y) begin
          $error("rotated_y: expected %0d, got %0d", due.y, rotated_y_o);
          failures++;
        end
        if (clipped_o !== due.clip) begin
          $error("clipped: expected %0d, got %0d", due.clip, clipped_o);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("point_rotator_2d verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int left, burst;
    bit paused;
    logic signed [CW-1:0] px, py;
    ctr_x = '0;
    ctr_y = '0;
    cos_q = 17'sd32768;
    sin_q = '0;
    paused = 0;

    add_point(16'sd0, 16'sd0, 1, 16'sd0, 16'sd0, 1'b0);
    add_point(16'sh7FFF, 16'sh8000, 1, 16'sh7FFF, 16'sh8000, 1'b0);
    add_point(16'sh8000, 16'sh7FFF, 1, 16'sh8000, 16'sh7FFF, 1'b0);
    add_point(16'sd1234, -16'sd567);
    add_write(pr2d_pkg::REG_CENTER_X, 16'h8000);
    add_point(16'sh7FFF, 16'sd0, 1, 16'sh7FFF, 16'sd0, 1'b0);
    add_write(pr2d_pkg::REG_CENTER_X, 16'h0000);
    add_write(pr2d_pkg::REG_ROTATION_ANGLE, 16'd11520);
    add_point(16'sh8000, 16'sh8000, 1, 16'sh7FFF, 16'sh7FFF, 1'b1);
    add_point(16'sh7FFF, 16'sd5, 1, -16'sd32767, -16'sd5, 1'b0);
    add_write(pr2d_pkg::REG_ROTATION_ANGLE, 16'd5760);
    add_point(16'sd3, 16'sh8000, 1, 16'sh7FFF, 16'sd3, 1'b1);
    add_write(pr2d_pkg::REG_ROTATION_ANGLE, 16'h8000);
    add_point(16'sd100, 16'sd200);
    add_write(pr2d_pkg::REG_ROTATION_ANGLE, 16'h7FFF);
    add_point(16'sh8000, 16'sh7FFF);
    add_write(pr2d_pkg::REG_CENTER_Y, 16'h7FFF);
    add_point(16'sd0, 16'sh8000);
    add_write(REG_SPARE, 16'hFFFF);
    add_point(16'sh7FFF, 16'sh7FFF);
    add_write(pr2d_pkg::REG_ROTATION_ANGLE, 16'd2880);
    add_point(16'sd1000, 16'sd0);
    add_write(pr2d_pkg::REG_ROTATION_ANGLE, 16'd17280);
    add_point(16'sd5, 16'sd0, 1, -16'sd32767, 16'sd32762, 1'b0);
    add_write(pr2d_pkg::REG_ROTATION_ANGLE, 16'd23040);
    add_point(16'sh8000, 16'sd12345);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_point(plan[k].px, plan[k].py, plan[k].typed, plan[k].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(pr2d_pkg::REG_CENTER_X, pick_center());
      write_reg(pr2d_pkg::REG_CENTER_Y, pick_center());
      if (ph == 5) write_reg(REG_SPARE, AW'($urandom));
      write_reg(pr2d_pkg::REG_ROTATION_ANGLE, pick_angle(ph));
      left = PHASE_POINTS;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > left) burst = left;
        repeat (burst) begin
          px = pick_coord(ctr_x);
          py = pick_coord(ctr_y);
          send_point(px, py, 0, '0);
        end
        left -= burst;
        if (ph == 3 && !paused && left < PHASE_POINTS / 2) begin
          drain();
          paused = 1;
        end else if (ph != 0 && left > 0) begin
          idle_for(($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3));
        end
      end
    end

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d points and %0d register writes over %0d settings; %0d results clipped.",
             n_points, n_writes, PHASES + 1, n_clipped);
    if (failures == 0 && rotated_points_due.size() == 0) begin
      $display("point_rotator_2d verification clean");
    end else begin
      $display("point_rotator_2d verification failed");
    end
    $finish;
  end

endmodule

>>> point_rotator_2d.f
rtl/pr2d_pkg.sv
rtl/pr2d_trig.sv
rtl/pr2d_pipe.sv
rtl/point_rotator_2d.sv
rtl/pr2d_checker.sv
dv/testbench.sv
